// ===== design/wsd_pkg.sv =====
// types and constants shared by the task deque controller, datapath and top level
// no dependencies
package wsd_pkg;

	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_POP   = 2'd1;
	localparam logic [1:0] MODE_STEAL = 2'd2;
	localparam logic [1:0] MODE_GIVE  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int unsigned OCC_W = 7;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic [63:0]      value_out;
		logic [1:0]       status;
		logic             last_of_run;
		logic [OCC_W-1:0] occupancy;
	} res_t;

	typedef struct packed {
		logic       wr_tail;
		logic       wr_head;
		logic       rd_tail;
		logic       rd_head;
		logic       steal_load;
		logic       emit;
		logic       last;
		logic [1:0] status;
	} wsd_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic run_last;
	} wsd_stat_t;

endpackage

// ===== design/wsd_datapath.sv =====
// deque datapath: entry memory, head slot, occupancy count, steal run counter, result registers
// depends on wsd_pkg
module wsd_datapath #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [63:0]      value,
	input  wsd_pkg::wsd_cmd_t cmd,
	output wsd_pkg::wsd_stat_t stat,
	output wsd_pkg::res_t    result,
	output logic             result_valid
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned OW = wsd_pkg::OCC_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
	localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [63:0]   mem [CAPACITY];
	logic [63:0]   rdata_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic          valid_q;
	logic          sel_mem_q;
	logic [1:0]    status_q;
	logic          last_q;
	logic [OW-1:0] occ_q;

	logic [SW-1:0] sum_tail;
	logic [SW-1:0] sum_pop;
	logic [AW-1:0] tail_slot;
	logic [AW-1:0] pop_slot;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [CW-1:0] half;
	logic [CW-1:0] want;
	logic [CW-1:0] slots_left;
	logic [CW-1:0] run_len;
	logic [CW-1:0] count_d;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          we;
	logic          re;

	always_comb begin
		sum_tail = SW'(head_q) + SW'(count_q);
		sum_pop  = sum_tail - SW'(1);
		if (sum_tail >= CAP_S) begin
			tail_slot = AW'(sum_tail - CAP_S);
		end else begin
			tail_slot = AW'(sum_tail);
		end
		if (sum_pop >= CAP_S) begin
			pop_slot = AW'(sum_pop - CAP_S);
		end else begin
			pop_slot = AW'(sum_pop);
		end
		head_dec   = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
		head_inc   = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
		half       = count_q >> 1;
		want       = (half == '0) ? CW'(1) : half;
		slots_left = CAP_C - CW'(head_q);
		run_len    = (want > slots_left) ? slots_left : want;
	end

	always_comb begin
		count_d = count_q;
		if (cmd.wr_tail || cmd.wr_head) begin
			count_d = count_q + CW'(1);
		end else if (cmd.rd_tail || cmd.rd_head) begin
			count_d = count_q - CW'(1);
		end
	end

	assign we    = cmd.wr_tail || cmd.wr_head;
	assign re    = cmd.rd_tail || cmd.rd_head;
	assign waddr = cmd.wr_head ? head_dec : tail_slot;
	assign raddr = cmd.rd_head ? head_q : pop_slot;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= value;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			valid_q <= cmd.emit;
			if (cmd.wr_head) begin
				head_q <= head_dec;
			end else if (cmd.rd_head) begin
				head_q <= head_inc;
			end
			if (cmd.steal_load) begin
				rem_q <= run_len;
			end else if (cmd.rd_head) begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sel_mem_q <= re;
			status_q  <= cmd.status;
			last_q    <= cmd.last;
			occ_q     <= OW'(count_d);
		end
	end

	assign stat.full     = (count_q >= CAP_C);
	assign stat.empty    = (count_q == '0);
	assign stat.run_last = (rem_q == CW'(1));

	assign result_valid       = valid_q;
	assign result.value_out   = sel_mem_q ? rdata_q : 64'd0;
	assign result.status      = status_q;
	assign result.last_of_run = last_q;
	assign result.occupancy   = occ_q;

endmodule

// ===== design/wsd_ctrl.sv =====
// deque controller: request decode and steal run sequencing
// depends on wsd_pkg
module wsd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         mode,
	input  wsd_pkg::wsd_stat_t stat,
	output wsd_pkg::wsd_cmd_t  cmd,
	output logic               busy
);

	typedef enum logic {
		S_IDLE,
		S_STEAL
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.last = 1'b1;
					unique case (mode)
						wsd_pkg::MODE_PUSH: begin
							cmd.emit = 1'b1;
							if (stat.full) begin
								cmd.status = wsd_pkg::ST_FULL;
							end else begin
								cmd.wr_tail = 1'b1;
								cmd.status  = wsd_pkg::ST_OK;
							end
						end
						wsd_pkg::MODE_GIVE: begin
							cmd.emit = 1'b1;
							if (stat.full) begin
								cmd.status = wsd_pkg::ST_FULL;
							end else begin
								cmd.wr_head = 1'b1;
								cmd.status  = wsd_pkg::ST_OK;
							end
						end
						wsd_pkg::MODE_POP: begin
							cmd.emit = 1'b1;
							if (stat.empty) begin
								cmd.status = wsd_pkg::ST_EMPTY;
							end else begin
								cmd.rd_tail = 1'b1;
								cmd.status  = wsd_pkg::ST_OK;
							end
						end
						wsd_pkg::MODE_STEAL: begin
							if (stat.empty) begin
								cmd.emit   = 1'b1;
								cmd.status = wsd_pkg::ST_EMPTY;
							end else begin
								cmd.steal_load = 1'b1;
							end
						end
						default: begin
							cmd = '0;
						end
					endcase
				end
			end
			S_STEAL: begin
				cmd.rd_head = 1'b1;
				cmd.emit    = 1'b1;
				cmd.status  = wsd_pkg::ST_OK;
				cmd.last    = stat.run_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.steal_load) begin
						state_q <= S_STEAL;
						busy_q  <= 1'b1;
					end
				end
				S_STEAL: begin
					if (stat.run_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

endmodule

// ===== design/work_stealing_task_deque.sv =====
// work stealing task deque top level: controller plus datapath
// depends on wsd_pkg, wsd_ctrl, wsd_datapath
//
// A request is taken when start is high and busy is low. Push, pop and give finish in the
// cycle they are taken and their single result shows in the next cycle, so these requests can
// follow each other every cycle. A steal that finds entries raises busy and streams its run
// of max(1, occupancy/2) entries, cut at the physical end of the buffer, one result per cycle,
// since each result costs one access of the single memory read port; the first result comes
// from the S_STEAL state through the result registers, and the block takes a new request the
// cycle after the last read. Failed requests give one result with a status code. Results come
// as a one-cycle strobe on result_valid and must be taken then. The occupancy field carries
// the low seven bits of the count. No clearing pass follows reset.
module work_stealing_task_deque #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  wsd_pkg::req_t request,
	output wsd_pkg::res_t result,
	output logic          result_valid
);

	wsd_pkg::wsd_cmd_t  cmd;
	wsd_pkg::wsd_stat_t stat;

	wsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (request.mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	wsd_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (request.value),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// ===== tb/work_stealing_task_deque_tb.sv =====
// self-checking testbench for the work stealing task deque: directed and random requests,
// with a scoreboard class that tracks the deque and predicts every result strobe
// depends on wsd_pkg and work_stealing_task_deque
`timescale 1ns / 100ps

module work_stealing_task_deque_tb;
	import wsd_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned STALL_LIMIT = 1000;

	class deque_scoreboard;
		logic [63:0] slots [DEPTH];
		bit [5:0] front;
		int unsigned held;
		res_t pending_results[$];
		int errors;
		int requests;
		int results;
		int full_refusals;
		int empty_refusals;
		int cut_runs;

		function void queue_result(logic [63:0] v, logic [1:0] st, logic last);
			res_t r;
			r.value_out = v;
			r.status = st;
			r.last_of_run = last;
			r.occupancy = held[OCC_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void note_request(req_t req);
			int unsigned run_len;
			int unsigned room;
			bit [5:0] idx;
			requests++;
			case (req.mode)
				MODE_PUSH, MODE_GIVE: begin
					if (held >= DEPTH) begin
						full_refusals++;
						queue_result('0, ST_FULL, 1'b1);
					end else begin
						if (req.mode == MODE_PUSH) begin
							idx = front + held[5:0];
							slots[idx] = req.value;
						end else begin
							front = front - 6'd1;
							slots[front] = req.value;
						end
						held++;
						queue_result('0, ST_OK, 1'b1);
					end
				end
				MODE_POP: begin
					if (held == 0) begin
						empty_refusals++;
						queue_result('0, ST_EMPTY, 1'b1);
					end else begin
						held--;
						idx = front + held[5:0];
						queue_result(slots[idx], ST_OK, 1'b1);
					end
				end
				default: begin
					if (held == 0) begin
						empty_refusals++;
						queue_result('0, ST_EMPTY, 1'b1);
					end else begin
						run_len = (held / 2 < 1) ? 1 : held / 2;
						room = DEPTH - front;
						if (run_len > room) begin
							run_len = room;
							cut_runs++;
						end
						for (int unsigned i = 0; i < run_len; i++) begin
							idx = front;
							front = front + 6'd1;
							held--;
							queue_result(slots[idx], ST_OK, i + 1 == run_len);
						end
					end
				end
			endcase
		endfunction

		function void report(string field, logic [63:0] exp_v, logic [63:0] got_v);
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
		endfunction

		function void check_result(res_t got);
			res_t exp_r;
			results++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %h", $time, got);
			end else begin
				exp_r = pending_results.pop_front();
				if (got.value_out !== exp_r.value_out)
					report("value_out", exp_r.value_out, got.value_out);
				if (got.status !== exp_r.status)
					report("status", 64'(exp_r.status), 64'(got.status));
				if (got.last_of_run !== exp_r.last_of_run)
					report("last_of_run", 64'(exp_r.last_of_run), 64'(got.last_of_run));
				if (got.occupancy !== exp_r.occupancy)
					report("occupancy", 64'(exp_r.occupancy), 64'(got.occupancy));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	res_t result;
	logic result_valid;

	deque_scoreboard sb = new();
	int sender_idle_pct;
	int unsigned quiet_cycles;

	work_stealing_task_deque #(.CAPACITY(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result(result),
		.result_valid(result_valid)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(result);
			if (start && !busy)
				sb.note_request(request);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("work_stealing_task_deque_tb: FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_request(input logic [1:0] mode, input logic [63:0] value);
		bit taken;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start = 1'b0;
			request.mode = 2'($urandom);
			request.value = {$urandom, $urandom};
			@(negedge clk);
		end
		start = 1'b1;
		request.mode = mode;
		request.value = value;
		do begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic random_requests(int n, int add_pct, int steal_pct);
		int r;
		logic [1:0] mode;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < add_pct)
				mode = $urandom_range(0, 1) ? MODE_PUSH : MODE_GIVE;
			else if (r < add_pct + steal_pct)
				mode = MODE_STEAL;
			else
				mode = MODE_POP;
			send_request(mode, pick_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		quiet_cycles = 0;
		sender_idle_pct = 28;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// refusals on empty, give wrapping below slot zero, steal cut at buffer end
		send_request(MODE_POP, '1);
		send_request(MODE_STEAL, '1);
		send_request(MODE_GIVE, '1);
		send_request(MODE_PUSH, '0);
		send_request(MODE_PUSH, 64'h0123_4567_89ab_cdef);
		send_request(MODE_PUSH, 64'hfedc_ba98_7654_3210);
		send_request(MODE_STEAL, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_STEAL, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
		send_request(MODE_PUSH, 64'h5555_5555_5555_5555);
		send_request(MODE_GIVE, 64'h8000_0000_0000_0000);
		send_request(MODE_GIVE, 64'h0000_0000_0000_0001);
		send_request(MODE_PUSH, '1);
		send_request(MODE_STEAL, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_STEAL, '0);
		send_request(MODE_STEAL, '0);

		// fill past full, then drain with long steal runs, then a mixed stretch
		random_requests(80, 95, 0);
		sender_idle_pct = 62;
		random_requests(30, 15, 35);
		sender_idle_pct = 0;
		random_requests(30, 50, 15);

		start = 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d requests and checked %0d results", sb.requests, sb.results);
		$display("saw %0d full and %0d empty refusals, %0d steal runs cut at buffer end",
			sb.full_refusals, sb.empty_refusals, sb.cut_runs);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("work_stealing_task_deque_tb: PASS");
		end else begin
			$display("work_stealing_task_deque_tb: FAIL");
		end
		$finish;
	end

endmodule
